@@ rtl/rtq_pkg.sv @@
package rtq_pkg;

    // Tuple and key geometry
    localparam int TUPLE_BYTES = 12;
    localparam int TUPLE_W     = 8 * TUPLE_BYTES;
    localparam int KEY_BITS    = 128;
    localparam int HASH_W      = 32;
    localparam int KEY_WIN_W   = HASH_W + 7;
    localparam int QUEUE_W     = 16;

    // Remainder chain: two dividend bits per cell
    localparam int MOD_BITS_PER_CELL = 2;
    localparam int MOD_CELLS         = HASH_W / MOD_BITS_PER_CELL;

    // Configuration register indexes
    localparam logic [1:0] REG_KEY_UPPER   = 2'd0;
    localparam logic [1:0] REG_KEY_LOWER   = 2'd1;
    localparam logic [1:0] REG_QUEUE_COUNT = 2'd2;

    // Item travelling along the hash cells
    typedef struct packed {
        logic                 hashed;
        logic [TUPLE_W-1:0]   tuple;
        logic [HASH_W-1:0]    hash;
        logic [QUEUE_W-1:0]   fallback;
    } rtq_hash_item_t;

    // Item travelling along the remainder cells
    typedef struct packed {
        logic                 hashed;
        logic [HASH_W-1:0]    hash;
        logic [QUEUE_W-1:0]   rem;
        logic [QUEUE_W-1:0]   fallback;
    } rtq_mod_item_t;

    // One restoring division step: shift in a dividend bit, subtract if it fits
    function automatic logic [QUEUE_W-1:0] rtq_mod_step(
        input logic [QUEUE_W-1:0] rem,
        input logic               bit_in,
        input logic [QUEUE_W-1:0] divisor
    );
        logic [QUEUE_W:0] trial;
        trial = {rem, bit_in};
        if (trial >= {1'b0, divisor})
        begin
            trial = trial - {1'b0, divisor};
        end
        return trial[QUEUE_W-1:0];
    endfunction

endpackage

@@ rtl/rss_toeplitz_queue_select.sv @@
// Receive-side-scaling queue selector.
// Slave stream: one parsed packet per item; tuser carries the IPv4 TCP/UDP
// flag, tdata the addresses, ports and fallback queue. Master stream: one
// result per item with the queue index and the 32-bit Toeplitz hash in tdata
// and the hashed flag in tuser.
// Configuration channel: cfg_index selects the key upper half, key lower
// half or queue count; it is always ready. Write it only while no item is
// in flight.
// Items pass 12 hash cells, one per tuple byte, then 16 remainder cells, two
// dividend bits each, the last of which is the output register. One item is
// taken per cycle unless a stalled receiver has filled the chain to the input.
// Each cell holds one item and moves it on whenever the next cell is empty or
// moving, so a stalled receiver fills the chain from the output back; input
// keeps being accepted until all 28 cells are full.
// Reset clears all cell valid bits and sets the key and queue count to zero.
module rss_toeplitz_queue_select (
    input  logic         clk,
    input  logic         rst_n,
    // Input items
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [111:0] s_tdata,   // saddr[31:0], daddr[63:32], src_port[79:64],
                                    // dst_port[95:80], fallback_queue[111:96]
    input  logic         s_tuser,   // is_ipv4_l4
    // Result items
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [47:0]  m_tdata,   // queue_index[15:0], flow_hash[47:16]
    output logic         m_tuser,   // hashed
    // Configuration writes
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [63:0]  cfg_data
);
    import rtq_pkg::*;

    logic [63:0]         key_upper_reg;
    logic [63:0]         key_lower_reg;
    logic [QUEUE_W-1:0]  queue_count_reg;
    logic [KEY_BITS-1:0] key;

    logic                hv [TUPLE_BYTES+1];
    logic                hr [TUPLE_BYTES+1];
    rtq_hash_item_t      hd [TUPLE_BYTES+1];
    logic                mv [MOD_CELLS+1];
    logic                mr [MOD_CELLS+1];
    rtq_mod_item_t       md [MOD_CELLS+1];

    // Register writes; unknown indexes are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_upper_reg   <= '0;
            key_lower_reg   <= '0;
            queue_count_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_KEY_UPPER:   key_upper_reg   <= cfg_data;
                REG_KEY_LOWER:   key_lower_reg   <= cfg_data;
                REG_QUEUE_COUNT: queue_count_reg <= cfg_data[QUEUE_W-1:0];
                default:         ;
            endcase
        end
    end

    assign key = {key_upper_reg, key_lower_reg};

    // Form the tuple in wire order and decide whether to hash
    assign hv[0]          = s_tvalid;
    assign s_tready       = hr[0];
    assign hd[0].hashed   = s_tuser && (queue_count_reg != '0);
    assign hd[0].tuple    = {s_tdata[31:0], s_tdata[63:32], s_tdata[79:64], s_tdata[95:80]};
    assign hd[0].hash     = '0;
    assign hd[0].fallback = s_tdata[111:96];

    // Hash cells, one tuple byte each
    for (genvar i = 0; i < TUPLE_BYTES; i++)
    begin : g_hash
        rtq_hash_cell #(.IDX(i)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (hv[i]),
            .in_ready  (hr[i]),
            .in_item   (hd[i]),
            .key       (key),
            .out_valid (hv[i+1]),
            .out_ready (hr[i+1]),
            .out_item  (hd[i+1])
        );
    end

    // Hand over to the remainder chain; unhashed items carry a zero hash
    assign mv[0]             = hv[TUPLE_BYTES];
    assign hr[TUPLE_BYTES]   = mr[0];
    assign md[0].hashed      = hd[TUPLE_BYTES].hashed;
    assign md[0].hash        = hd[TUPLE_BYTES].hashed ? hd[TUPLE_BYTES].hash : '0;
    assign md[0].rem         = '0;
    assign md[0].fallback    = hd[TUPLE_BYTES].fallback;

    // Remainder cells, two dividend bits each
    for (genvar j = 0; j < MOD_CELLS; j++)
    begin : g_mod
        rtq_mod_cell #(.IDX(j)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (mv[j]),
            .in_ready  (mr[j]),
            .in_item   (md[j]),
            .divisor   (queue_count_reg),
            .out_valid (mv[j+1]),
            .out_ready (mr[j+1]),
            .out_item  (md[j+1])
        );
    end

    // Drive the result stream from the last cell
    assign m_tvalid         = mv[MOD_CELLS];
    assign mr[MOD_CELLS]    = m_tready;
    assign m_tdata[15:0]    = md[MOD_CELLS].hashed ? md[MOD_CELLS].rem
                                                   : md[MOD_CELLS].fallback;
    assign m_tdata[47:16]   = md[MOD_CELLS].hash;
    assign m_tuser          = md[MOD_CELLS].hashed;

    // A fallback result never carries a hash
    a_fallback_zero_hash: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[47:16] == '0)
        else $error("fallback result with nonzero hash");

    // A hashed queue index lies below the queue count
    a_queue_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[15:0] < queue_count_reg)
        else $error("hashed queue index out of range");

    // Input back-pressure only ever comes from a stalled receiver
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output stall");

endmodule

@@ rtl/rtq_hash_cell.sv @@
module rtq_hash_cell #(
    parameter int IDX = 0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  rtq_pkg::rtq_hash_item_t       in_item,
    input  logic [rtq_pkg::KEY_BITS-1:0]  key,
    output logic                          out_valid,
    input  logic                          out_ready,
    output rtq_pkg::rtq_hash_item_t       out_item
);
    import rtq_pkg::*;

    localparam int WIN_TOP = KEY_BITS - 1 - 8 * IDX;

    logic                 valid_reg;
    logic                 valid_next;
    rtq_hash_item_t       item_reg;
    rtq_hash_item_t       item_next;
    logic [7:0]           tuple_byte;
    logic [KEY_WIN_W-1:0] key_win;
    logic [HASH_W-1:0]    acc;

    // Take the leading tuple byte and the key bits it spans
    assign tuple_byte = in_item.tuple[TUPLE_W-1 -: 8];
    assign key_win    = key[WIN_TOP -: KEY_WIN_W];

    // XOR in one key window for every set bit of the byte
    always_comb
    begin
        acc = '0;
        for (int b = 0; b < 8; b++)
        begin
            if (tuple_byte[7-b])
            begin
                acc = acc ^ key_win[KEY_WIN_W-1-b -: HASH_W];
            end
        end
    end

    // Advance when the next cell can take the held item
    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        item_next          = in_item;
        item_next.tuple    = {in_item.tuple[TUPLE_W-9:0], 8'h00};
        item_next.hash     = in_item.hash ^ acc;
        valid_next         = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

@@ rtl/rtq_mod_cell.sv @@
module rtq_mod_cell #(
    parameter int IDX = 0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  rtq_pkg::rtq_mod_item_t        in_item,
    input  logic [rtq_pkg::QUEUE_W-1:0]   divisor,
    output logic                          out_valid,
    input  logic                          out_ready,
    output rtq_pkg::rtq_mod_item_t        out_item
);
    import rtq_pkg::*;

    localparam int BIT_HI = HASH_W - 1 - MOD_BITS_PER_CELL * IDX;

    logic          valid_reg;
    logic          valid_next;
    rtq_mod_item_t item_reg;
    rtq_mod_item_t item_next;

    // Two restoring steps on the next dividend bits, most significant first
    always_comb
    begin
        item_next     = in_item;
        item_next.rem = rtq_mod_step(
            rtq_mod_step(in_item.rem, in_item.hash[BIT_HI], divisor),
            in_item.hash[BIT_HI-1], divisor);
        valid_next    = in_ready ? in_valid : valid_reg;
    end

    // Advance when the next cell can take the held item
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule
